// File: sv/pfc_pkg.sv
package pfc_pkg;

	localparam int SIDE    = 5;
	localparam int CELLS   = SIDE * SIDE;
	localparam int LETTERS = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] cell_t;
	typedef logic [2:0] coord_t;

	localparam letter_t LETTER_I = letter_t'(8'h49 - 8'h41);
	localparam letter_t LETTER_J = letter_t'(8'h4a - 8'h41);
	localparam letter_t LETTER_X = letter_t'(8'h58 - 8'h41);
	localparam letter_t LETTER_LAST = letter_t'(LETTERS - 1);
	localparam cell_t   CELL_FULL = cell_t'(CELLS);

	localparam logic [1:0] OP_KEY_CHAR = 2'd0;
	localparam logic [1:0] OP_KEY_END  = 2'd1;
	localparam logic [1:0] OP_TEXT     = 2'd2;
	localparam logic [1:0] OP_MSG_END  = 2'd3;

	typedef struct packed {
		logic    is_letter;
		logic    upper;
		letter_t idx;
	} folded_t;

	typedef struct packed {
		cell_t cell_a;
		cell_t cell_b;
	} cell_pair_t;

	function automatic folded_t fold_char(input logic [7:0] ch);
		folded_t f;
		f.is_letter = 1'b0;
		f.upper     = 1'b1;
		f.idx       = '0;
		if (ch >= 8'h41 && ch <= 8'h5a) begin
			f.is_letter = 1'b1;
			f.idx       = letter_t'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin
			f.is_letter = 1'b1;
			f.upper     = 1'b0;
			f.idx       = letter_t'(ch - 8'h61);
		end
		if (f.idx == LETTER_J) begin
			f.idx = LETTER_I;
		end
		return f;
	endfunction

	function automatic logic [7:0] cased(input letter_t idx, input logic upper);
		return upper ? 8'(8'h41 + {3'b000, idx}) : 8'(8'h61 + {3'b000, idx});
	endfunction

endpackage

// File: sv/playfair_digraph_cipher_core.sv
// Key character, text letter that is held, message end with nothing held: taken in ST_IDLE.
// Key end: one alphabet letter per cycle against the letter-used flags.
// Completed pair: ST_LPA, ST_LPB, ST_SQA, ST_SQB; ST_EMIT_A then ST_EMIT_B send the letters,
// each held by output stalls, then the next request is taken; each table RAM is read twice.
// Reset (async, active low) clears flags, counts, hold and output; RAM contents stay.
module playfair_digraph_cipher_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] character,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import pfc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WALK, ST_LPA, ST_LPB, ST_SQA, ST_SQB, ST_EMIT_A, ST_EMIT_B
	} state_t;

	state_t               state_q;
	logic                 dir_q;
	logic [LETTERS-1:0]   used_q;
	cell_t                fill_q;
	logic                 complete_q;
	logic                 holding_q;
	letter_t              held_idx_q;
	logic                 held_up_q;
	letter_t              ib_q;
	logic                 ub_q;
	letter_t              walk_q;
	cell_t                pa_q;
	cell_t                cell_b_q;
	letter_t              oa_q;
	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 last_q;

	folded_t              fin;
	logic                 accept;
	logic [LETTERS-1:0]   eff_used;
	cell_t                eff_fill;
	letter_t              place_l;
	logic                 place;
	logic                 out_free;

	logic                 sq_re;
	cell_t                sq_raddr;
	letter_t              sq_rdata;
	logic                 lp_re;
	letter_t              lp_raddr;
	cell_t                lp_rdata;
	cell_pair_t           cells;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		fin      = fold_char(character);
		eff_used = (state_q == ST_IDLE && complete_q) ? '0 : used_q;
		eff_fill = (state_q == ST_IDLE && complete_q) ? '0 : fill_q;
		place_l  = (state_q == ST_WALK) ? walk_q : fin.idx;
		place    = 1'b0;
		if (state_q == ST_WALK) begin
			place = (walk_q != LETTER_J) && !eff_used[place_l] && (eff_fill < CELL_FULL);
		end else if (accept && operation == OP_KEY_CHAR) begin
			place = fin.is_letter && !eff_used[place_l] && (eff_fill < CELL_FULL);
		end
	end

	assign lp_re    = (state_q == ST_LPA) || (state_q == ST_LPB);
	assign lp_raddr = (state_q == ST_LPA) ? held_idx_q : ib_q;
	assign sq_re    = (state_q == ST_SQA) || (state_q == ST_SQB);
	assign sq_raddr = (state_q == ST_SQA) ? cells.cell_a : cell_b_q;

	pfc_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square (
		.clk   (clk),
		.we    (place),
		.waddr (eff_fill),
		.wdata (place_l),
		.re    (sq_re),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	pfc_ram #(.WIDTH(5), .DEPTH(LETTERS)) u_letter_place (
		.clk   (clk),
		.we    (place),
		.waddr (place_l),
		.wdata (eff_fill),
		.re    (lp_re),
		.raddr (lp_raddr),
		.rdata (lp_rdata)
	);

	pfc_geom u_geom (
		.pa    (pa_q),
		.pb    (lp_rdata),
		.dir   (dir_q),
		.cells (cells)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= 1'b0;
			used_q      <= '0;
			fill_q      <= '0;
			complete_q  <= 1'b0;
			holding_q   <= 1'b0;
			held_idx_q  <= '0;
			held_up_q   <= 1'b0;
			ib_q        <= '0;
			ub_q        <= 1'b0;
			pa_q        <= '0;
			cell_b_q    <= '0;
			oa_q        <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			last_q      <= 1'b0;
			walk_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dir_q <= cfg_data;
			end
			// drop a taken result
			if (out_valid_q && !out_stall && state_q != ST_EMIT_A && state_q != ST_EMIT_B) begin
				out_valid_q <= 1'b0;
			end
			if (place) begin
				fill_q <= cell_t'(eff_fill + 5'd1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_KEY_CHAR: begin
								used_q <= eff_used | (place ? (LETTERS'(1) << place_l) : '0);
								if (complete_q) begin
									complete_q <= 1'b0;
									holding_q  <= 1'b0;
									if (!place) begin
										fill_q <= '0;
									end
								end
							end
							OP_KEY_END: begin
								if (!complete_q) begin
									walk_q  <= '0;
									state_q <= ST_WALK;
								end
							end
							OP_TEXT: begin
								if (complete_q && fin.is_letter) begin
									if (!holding_q) begin
										held_idx_q <= fin.idx;
										held_up_q  <= fin.upper;
										holding_q  <= 1'b1;
									end else begin
										ib_q      <= fin.idx;
										ub_q      <= fin.upper;
										holding_q <= 1'b0;
										state_q   <= ST_LPA;
									end
								end
							end
							OP_MSG_END: begin
								if (complete_q && holding_q) begin
									ib_q      <= LETTER_X;
									ub_q      <= 1'b1;
									holding_q <= 1'b0;
									state_q   <= ST_LPA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (place) begin
						used_q <= used_q | (LETTERS'(1) << place_l);
					end
					if (walk_q == LETTER_LAST) begin
						complete_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						walk_q <= letter_t'(walk_q + 5'd1);
					end
				end
				ST_LPA: begin
					state_q <= ST_LPB;
				end
				ST_LPB: begin
					pa_q    <= lp_rdata;
					state_q <= ST_SQA;
				end
				ST_SQA: begin
					cell_b_q <= cells.cell_b;
					state_q  <= ST_SQB;
				end
				ST_SQB: begin
					oa_q    <= sq_rdata;
					state_q <= ST_EMIT_A;
				end
				ST_EMIT_A: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= cased(oa_q, held_up_q);
						last_q      <= 1'b0;
						state_q     <= ST_EMIT_B;
					end
				end
				ST_EMIT_B: begin
					// square read data holds the second letter until the next read
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= cased(sq_rdata, ub_q);
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CELL_FULL)
		else $error("fill count beyond square size");

	a_complete_full: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (fill_q == CELL_FULL))
		else $error("square marked complete while not full");

	a_result_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (in_stall && !last_q))
		else $error("result started outside a pair");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_B) |-> (out_valid_q && !last_q))
		else $error("second letter pending without first");

endmodule

// File: sv/pfc_ram.sv
module pfc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/pfc_geom.sv
module pfc_geom (
	input  pfc_pkg::cell_t      pa,
	input  pfc_pkg::cell_t      pb,
	input  logic                dir,
	output pfc_pkg::cell_pair_t cells
);
	import pfc_pkg::*;

	function automatic coord_t row_of(input cell_t c);
		if (c >= cell_t'(4 * SIDE)) return coord_t'(4);
		else if (c >= cell_t'(3 * SIDE)) return coord_t'(3);
		else if (c >= cell_t'(2 * SIDE)) return coord_t'(2);
		else if (c >= cell_t'(SIDE)) return coord_t'(1);
		else return coord_t'(0);
	endfunction

	function automatic coord_t step(input coord_t v, input logic back);
		if (back) begin
			return (v == '0) ? coord_t'(SIDE - 1) : coord_t'(v - 3'd1);
		end
		return (v == coord_t'(SIDE - 1)) ? '0 : coord_t'(v + 3'd1);
	endfunction

	function automatic cell_t cell_at(input coord_t r, input coord_t c);
		return cell_t'(int'(r) * SIDE + int'(c));
	endfunction

	coord_t ra, ca, rb, cb;

	always_comb begin
		ra = row_of(pa);
		rb = row_of(pb);
		ca = coord_t'(pa - cell_t'(int'(ra) * SIDE));
		cb = coord_t'(pb - cell_t'(int'(rb) * SIDE));
		if (ra == rb) begin
			cells.cell_a = cell_at(ra, step(ca, dir));
			cells.cell_b = cell_at(rb, step(cb, dir));
		end else if (ca == cb) begin
			cells.cell_a = cell_at(step(ra, dir), ca);
			cells.cell_b = cell_at(step(rb, dir), cb);
		end else begin
			cells.cell_a = cell_at(ra, cb);
			cells.cell_b = cell_at(rb, ca);
		end
	end

endmodule

// File: bench/playfair_digraph_cipher_checker.sv
`timescale 1ns / 100ps

module playfair_digraph_cipher_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] operation,
	input  logic [7:0] character,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_char,
	input  logic       last,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_data,
	output int         mismatches,
	output int         outstanding
);
	import pfc_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} cipher_letter_t;

	cipher_letter_t cipher_q[$];

	letter_t    grid [CELLS];
	cell_t      spot [LETTERS];
	logic       letter_taken [LETTERS];
	int         filled;
	logic       complete;
	logic       holding;
	logic [7:0] held;
	logic       decrypt;

	function automatic logic to_letter(input logic [7:0] ch, output letter_t idx,
			output logic upper);
		idx   = '0;
		upper = 1'b1;
		if (ch >= "A" && ch <= "Z") begin
			idx = letter_t'(ch - "A");
		end else if (ch >= "a" && ch <= "z") begin
			idx   = letter_t'(ch - "a");
			upper = 1'b0;
		end else begin
			return 1'b0;
		end
		if (idx == LETTER_J) begin
			idx = LETTER_I;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] spell(input letter_t idx, input logic upper);
		logic [7:0] base;
		base = upper ? "A" : "a";
		return base + {3'b000, idx};
	endfunction

	task automatic place(input letter_t l);
		if (!letter_taken[l] && filled < CELLS) begin
			grid[filled]    = l;
			spot[l]         = cell_t'(filled);
			letter_taken[l] = 1'b1;
			filled++;
		end
	endtask

	task automatic clear_key();
		for (int l = 0; l < LETTERS; l++) begin
			letter_taken[l] = 1'b0;
		end
		filled   = 0;
		complete = 1'b0;
		held     = '0;
		holding  = 1'b0;
	endtask

	task automatic encode_pair(input logic [7:0] a, input logic [7:0] b);
		letter_t ia, ib, oa, ob;
		logic    ua, ub;
		int      ra, ca, rb, cb, s;
		void'(to_letter(a, ia, ua));
		void'(to_letter(b, ib, ub));
		ra = int'(spot[ia]) / SIDE;
		ca = int'(spot[ia]) % SIDE;
		rb = int'(spot[ib]) / SIDE;
		cb = int'(spot[ib]) % SIDE;
		s  = decrypt ? SIDE - 1 : 1;
		if (ra == rb) begin
			oa = grid[ra * SIDE + (ca + s) % SIDE];
			ob = grid[rb * SIDE + (cb + s) % SIDE];
		end else if (ca == cb) begin
			oa = grid[((ra + s) % SIDE) * SIDE + ca];
			ob = grid[((rb + s) % SIDE) * SIDE + cb];
		end else begin
			oa = grid[ra * SIDE + cb];
			ob = grid[rb * SIDE + ca];
		end
		cipher_q.push_back('{spell(oa, ua), 1'b0});
		cipher_q.push_back('{spell(ob, ub), 1'b1});
	endtask

	task automatic apply_request(input logic [1:0] op, input logic [7:0] ch);
		letter_t    idx;
		logic       upper;
		logic [7:0] c;
		case (op)
		OP_KEY_CHAR: begin
			if (complete) begin
				clear_key();
			end
			if (to_letter(ch, idx, upper)) begin
				place(idx);
			end
		end
		OP_KEY_END: begin
			for (int l = 0; l < LETTERS; l++) begin
				if (letter_t'(l) != LETTER_J) begin
					place(letter_t'(l));
				end
			end
			complete = 1'b1;
		end
		OP_TEXT: begin
			if (complete && to_letter(ch, idx, upper)) begin
				c = spell(idx, upper);
				if (!holding) begin
					held    = c;
					holding = 1'b1;
				end else begin
					holding = 1'b0;
					encode_pair(held, c);
				end
			end
		end
		OP_MSG_END: begin
			if (complete && holding) begin
				holding = 1'b0;
				encode_pair(held, "X");
			end
		end
		default: begin
		end
		endcase
	endtask

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cipher_letter_t want;
		if (!arst_n) begin
			cipher_q.delete();
			clear_key();
			decrypt     = 1'b0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				decrypt = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					report($sformatf("unexpected result char %02h last %0b", out_char, last));
				end else begin
					want = cipher_q.pop_front();
					if (out_char !== want.ch) begin
						report($sformatf("out_char expected %02h got %02h", want.ch, out_char));
					end
					if (last !== want.last) begin
						report($sformatf("last expected %0b got %0b", want.last, last));
					end
				end
			end
			if (in_valid && !in_stall) begin
				apply_request(operation, character);
			end
			outstanding <= cipher_q.size();
		end
	end

endmodule

// File: bench/playfair_digraph_cipher_core_test.sv
`timescale 1ns / 100ps

module playfair_digraph_cipher_core_test;
	import pfc_pkg::*;

	localparam int LIMIT        = 500_000;
	localparam int SETTLE       = 40;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 1250;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] operation;
	logic [7:0] character;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;

	int   mismatches;
	int   outstanding;
	int   requests_sent;
	int   cycle_count;
	logic steady;

	playfair_digraph_cipher_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.character (character),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	playfair_digraph_cipher_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.character   (character),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic is_alpha(input logic [7:0] ch);
		return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
	endfunction

	function automatic logic [7:0] any_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? "A" : "a";
		return base + 8'($urandom_range(0, 25));
	endfunction

	task automatic offer(input logic [1:0] op, input logic [7:0] ch);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		character <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!(op == OP_TEXT && !is_alpha(ch)) && op != OP_MSG_END) begin
			requests_sent++;
		end
	endtask

	// drop valid and wait for the block to drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_direction(input logic value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic play_session();
		int key_len;
		int text_len;
		steady   = ($urandom_range(0, 4) == 0);
		key_len  = $urandom_range(0, 14);
		repeat (key_len) begin
			offer(OP_KEY_CHAR, $urandom_range(0, 7) == 0 ? 8'($urandom) : any_letter());
		end
		if ($urandom_range(0, 9) != 0) begin
			offer(OP_KEY_END, 8'($urandom));
		end
		text_len = $urandom_range(1, 40);
		repeat (text_len) begin
			if ($urandom_range(0, 19) == 0) begin
				offer(2'($urandom), 8'($urandom));
			end else begin
				offer(OP_TEXT, $urandom_range(0, 7) == 0 ? 8'($urandom) : any_letter());
			end
		end
		if ($urandom_range(0, 2) != 0) begin
			offer(OP_MSG_END, 8'($urandom));
		end
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : drain
		int hold;
		int taken;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == 60 || taken == 400) begin
				hold = LONG_HOLD;
			end else begin
				hold = steady ? 0 : $urandom_range(0, 9);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		steady        = 1'b0;
		requests_sent = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		operation <= OP_KEY_CHAR;
		character <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(OP_TEXT, "Q");
		offer(OP_MSG_END, 8'hff);
		offer(OP_KEY_CHAR, 8'h00);
		offer(OP_KEY_CHAR, "p");
		offer(OP_KEY_CHAR, "j");
		offer(OP_KEY_CHAR, "L");
		offer(OP_KEY_CHAR, "A");
		offer(OP_KEY_CHAR, "p");
		offer(OP_KEY_CHAR, 8'hff);
		offer(OP_KEY_CHAR, "Z");
		offer(OP_KEY_END, 8'h00);
		offer(OP_KEY_END, 8'hff);
		offer(OP_TEXT, "P");
		offer(OP_TEXT, "z");
		offer(OP_TEXT, "j");
		offer(OP_TEXT, "V");
		offer(OP_TEXT, "e");
		offer(OP_TEXT, "e");
		offer(OP_TEXT, "1");
		offer(OP_TEXT, "G");
		offer(OP_TEXT, "y");
		offer(OP_TEXT, "a");
		offer(OP_MSG_END, 8'h00);
		offer(OP_MSG_END, 8'h55);
		settle();

		// switch direction between the two letters of a pair
		write_direction(1'b1);
		offer(OP_TEXT, "m");
		settle();
		write_direction(1'b0);
		offer(OP_TEXT, "O");
		offer(OP_TEXT, "w");
		offer(OP_KEY_CHAR, "q");
		offer(OP_KEY_END, 8'haa);
		settle();
		write_direction(1'b1);

		requests_sent = 0;
		while (requests_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				settle();
				write_direction(1'($urandom_range(0, 1)));
			end
			play_session();
		end
		settle();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
